### src/tetc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tetc_pkg: shared constants for the tetrahedron circumcenter core
// Holds the configuration word layout used by the port interface and the core.
// ============================================================================
package tetc_pkg;

    // Width of the volume threshold register.
    localparam int CFG_W = 16;

    typedef logic [CFG_W-1:0] cfg_word_t;

    // Threshold value after reset.
    localparam cfg_word_t MIN_VOL_RST = cfg_word_t'(1);

endpackage

### src/tetc_pts_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tetc_pts_if: vertex input channel
// Carries the four vertices of one tetrahedron per beat.
// ============================================================================
interface tetc_pts_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p0_z;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;

    modport source (
        output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
        output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
        input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

### src/tetc_ctr_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tetc_ctr_if: circumcenter result channel
// Carries one fixed point center and the degenerate flag per beat.
// ============================================================================
interface tetc_ctr_if #(
    parameter int OUT_BITS = 48
) ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
    logic signed [OUT_BITS-1:0] center_z;
    logic                       degenerate;

    modport source (
        output valid, center_x, center_y, center_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, degenerate,
        output ready
    );
endinterface

### src/tetc_cfg_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tetc_cfg_if: threshold register write channel
// One beat writes the six-times-volume threshold.
// ============================================================================
interface tetc_cfg_if ();
    import tetc_pkg::*;

    logic      valid;
    logic      ready;
    cfg_word_t data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### src/tet_circumcenter_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tet_circumcenter_core: pipelined tetrahedron circumcenter
// Exact integer Gram / cross product math followed by a rounded divide.
// ============================================================================
// Usage:
//   pts carries one tetrahedron (p0..p3, signed integer coordinates) per beat.
//   ctr returns its circumcenter in fixed point with FRAC_BITS fraction bits,
//   rounded to nearest with ties away from zero and saturated to OUT_BITS,
//   plus a degenerate flag set when six times the signed volume is below the
//   threshold register (so inverted tetrahedra are flagged as well).
//   cfg writes the threshold; it is always ready and should only be written
//   while no beat is in flight.
// Timing:
//   The pipeline is QB + 8 stages deep, where QB = max(OUT_BITS,
//   COORD_BITS + FRAC_BITS) + 1 (57 stages with the defaults). The depth is
//   set by the restoring divider, which retires one quotient bit per stage.
//   One beat is accepted every cycle unless every stage is full and the
//   receiver stalls; every beat yields exactly one result.
// Stalls and reset:
//   Each stage holds its beat while the next stage is full and stalled, and
//   empty stages keep filling, so inputs are taken while a result waits as long as a stage is empty.
//   Reset empties the pipeline and sets the threshold to 1.
// ============================================================================
module tet_circumcenter_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    parameter int OUT_BITS   = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    tetc_pts_if.sink    pts,
    tetc_ctr_if.source  ctr,
    tetc_cfg_if.sink    cfg
);
    import tetc_pkg::*;

    // Widths of the intermediate values.
    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 1;            // edge vector component
    localparam int XW   = 2 * CB + 3;        // cross product / squared length
    localparam int SUW  = 2 * CB + 2;        // squared length, unsigned
    localparam int SLW  = CB + 1;            // low split of squared length
    localparam int PPW  = 3 * CB + 5;        // partial product
    localparam int DDW  = 3 * CB + 4;        // six times volume
    localparam int DIVW = 3 * CB + 5;        // divisor 2D
    localparam int NUMW = 4 * CB + 6;        // numerator
    localparam int NW   = NUMW + FRAC_BITS + 1;
    localparam int QB   = ((OUT_BITS > CB + FRAC_BITS) ? OUT_BITS : CB + FRAC_BITS) + 1;
    localparam int NPW  = NW + QB;
    localparam int DVW  = DIVW + 1;
    localparam int CMW  = DDW + CFG_W + 1;
    localparam int SUMW = QB + 2;
    localparam int NST  = QB + 8;

    localparam logic signed [SUMW-1:0] OMAX = (SUMW'(1) <<< (OUT_BITS - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] OMIN = -OMAX - SUMW'(1);

    typedef struct packed {
        logic                 neg;
        logic                 zero;
        logic                 ovf;
        logic signed [CB-1:0] p0;
    } side_t;

    // ------------------------------------------------------------------
    // Threshold register.
    cfg_word_t min_vol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_vol_reg <= MIN_VOL_RST;
        end
        else if (cfg.valid)
        begin
            min_vol_reg <= cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and the ready chain; a stage loads when it is empty
    // or its beat moves on.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   rdy;

    assign rdy[NST]  = ctr.ready;
    assign pts.ready = rdy[0];
    assign ctr.valid = vld_reg[NST-1];
    assign vld_next  = {vld_reg[NST-2:0], pts.valid};

    for (genvar i = 0; i < NST; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking.
    logic signed [CB-1:0] pin [4][3];

    assign pin[0][0] = pts.p0_x;
    assign pin[0][1] = pts.p0_y;
    assign pin[0][2] = pts.p0_z;
    assign pin[1][0] = pts.p1_x;
    assign pin[1][1] = pts.p1_y;
    assign pin[1][2] = pts.p1_z;
    assign pin[2][0] = pts.p2_x;
    assign pin[2][1] = pts.p2_y;
    assign pin[2][2] = pts.p2_z;
    assign pin[3][0] = pts.p3_x;
    assign pin[3][1] = pts.p3_y;
    assign pin[3][2] = pts.p3_z;

    // p0 travels alongside the front stages.
    logic signed [CB-1:0] p0_reg [6][3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            if (rdy[i])
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p0_reg[i][k] <= (i == 0) ? pin[0][k] : p0_reg[(i == 0) ? 0 : i - 1][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: edge vectors from p0.
    logic signed [EW-1:0] e_reg  [3][3];
    logic signed [EW-1:0] e_next [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_next[i][k] = EW'(pin[i+1][k]) - EW'(pin[0][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            e_reg <= e_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squared edge lengths and the three cross products
    // (row 0 is b x c, row 1 is c x a, row 2 is a x b).
    logic [SUW-1:0]       s_reg   [3];
    logic [SUW-1:0]       s_next  [3];
    logic signed [XW-1:0] x_reg   [3][3];
    logic signed [XW-1:0] x_next  [3][3];
    logic signed [EW-1:0] e0_reg  [3];
    logic signed [XW-1:0] sq_sum  [3];

    always_comb
    begin
        int k1;
        int k2;
        int ju;
        int jv;
        for (int i = 0; i < 3; i++)
        begin
            sq_sum[i] = XW'(e_reg[i][0]) * XW'(e_reg[i][0])
                      + XW'(e_reg[i][1]) * XW'(e_reg[i][1])
                      + XW'(e_reg[i][2]) * XW'(e_reg[i][2]);
            s_next[i] = sq_sum[i][SUW-1:0];
        end
        for (int j = 0; j < 3; j++)
        begin
            ju = (j == 2) ? 0 : j + 1;
            jv = (j == 0) ? 2 : j - 1;
            for (int k = 0; k < 3; k++)
            begin
                k1 = (k == 2) ? 0 : k + 1;
                k2 = (k == 0) ? 2 : k - 1;
                x_next[j][k] = XW'(e_reg[ju][k1]) * XW'(e_reg[jv][k2])
                             - XW'(e_reg[ju][k2]) * XW'(e_reg[jv][k1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s_reg  <= s_next;
            x_reg  <= x_next;
            e0_reg <= e_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: split products of squared length and cross product, and the
    // three volume products.
    logic signed [PPW-1:0] pl_reg  [3][3];
    logic signed [PPW-1:0] pl_next [3][3];
    logic signed [PPW-1:0] ph_reg  [3][3];
    logic signed [PPW-1:0] ph_next [3][3];
    logic signed [DDW-1:0] dp_reg  [3];
    logic signed [DDW-1:0] dp_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dp_next[k] = DDW'(e0_reg[k]) * DDW'(x_reg[0][k]);
            for (int j = 0; j < 3; j++)
            begin
                pl_next[k][j] = PPW'($signed({1'b0, s_reg[j][SLW-1:0]}))
                              * PPW'(x_reg[j][k]);
                ph_next[k][j] = PPW'($signed({1'b0, s_reg[j][SUW-1:SLW]}))
                              * PPW'(x_reg[j][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            dp_reg <= dp_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: recombine the split products; sum the volume.
    logic signed [NUMW-1:0] term_reg  [3][3];
    logic signed [NUMW-1:0] term_next [3][3];
    logic signed [DDW-1:0]  d_reg;
    logic signed [DDW-1:0]  d_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_next[k][j] = (NUMW'(ph_reg[k][j]) <<< SLW) + NUMW'(pl_reg[k][j]);
            end
        end
        d_next = dp_reg[0] + dp_reg[1] + dp_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            term_reg <= term_next;
            d_reg    <= d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerators, divisor 2D and the threshold compare.
    logic signed [NUMW-1:0] num_reg  [3];
    logic signed [NUMW-1:0] num_next [3];
    logic signed [DIVW-1:0] div_reg;
    logic                   dg4_reg;
    logic                   dg4_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_next[k] = term_reg[k][0] + term_reg[k][1] + term_reg[k][2];
        end
        dg4_next = $signed(CMW'(d_reg)) < $signed(CMW'(min_vol_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            num_reg <= num_next;
            div_reg <= DIVW'(d_reg) <<< 1;
            dg4_reg <= dg4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: magnitudes and quotient signs.
    logic [NUMW-1:0] nm_reg   [3];
    logic [NUMW-1:0] nm_next  [3];
    logic [DIVW-1:0] dm_reg;
    logic [DIVW-1:0] dm_next;
    logic [2:0]      neg_reg;
    logic [2:0]      neg_next;
    logic [2:0]      zero_reg;
    logic [2:0]      zero_next;
    logic            dg5_reg;

    always_comb
    begin
        dm_next = div_reg[DIVW-1] ? DIVW'(-div_reg) : DIVW'(div_reg);
        for (int k = 0; k < 3; k++)
        begin
            nm_next[k]   = num_reg[k][NUMW-1] ? NUMW'(-num_reg[k]) : NUMW'(num_reg[k]);
            zero_next[k] = (num_reg[k] == '0);
            neg_next[k]  = (num_reg[k][NUMW-1] ^ div_reg[DIVW-1]) && !zero_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            nm_reg   <= nm_next;
            dm_reg   <= dm_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
            dg5_reg  <= dg4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider state. Index 0 is stage 6 (setup and overflow check), index t
    // is the stage that has produced t quotient bits. The remainder holds the
    // partial remainder, nq the unused dividend bits with quotient bits
    // shifted in from the bottom.
    logic [DVW-1:0] dv_rem_reg  [QB+1][3];
    logic [QB-1:0]  dv_nq_reg   [QB+1][3];
    side_t          dv_side_reg [QB+1][3];
    logic [DVW-1:0] dv_d_reg    [QB+1];
    logic           dv_dg_reg   [QB+1];

    // Stage 6: dividend 2*|num|*2^F + |div| over divisor 2*|div|.
    logic [NPW-1:0] nfull    [3];
    logic [NW-1:0]  ntop     [3];
    logic [DVW-1:0] dv0_next;
    side_t          side0_next [3];

    always_comb
    begin
        dv0_next = DVW'(dm_reg) << 1;
        for (int k = 0; k < 3; k++)
        begin
            nfull[k] = (NPW'(nm_reg[k]) << (FRAC_BITS + 1)) + NPW'(dm_reg);
            ntop[k]  = nfull[k][NPW-1:QB];
            side0_next[k].neg  = neg_reg[k];
            side0_next[k].zero = zero_reg[k];
            side0_next[k].ovf  = !zero_reg[k] && (ntop[k] >= NW'(dv0_next));
            side0_next[k].p0   = p0_reg[5][k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dv_rem_reg[0][k]  <= ntop[k][DVW-1:0];
                dv_nq_reg[0][k]   <= nfull[k][QB-1:0];
                dv_side_reg[0][k] <= side0_next[k];
            end
            dv_d_reg[0]  <= dv0_next;
            dv_dg_reg[0] <= dg5_reg;
        end
    end

    // One restoring step per stage.
    for (genvar t = 1; t <= QB; t++)
    begin : g_div
        logic [DVW:0]   trial [3];
        logic [DVW:0]   diff  [3];
        logic [2:0]     ge;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                trial[k] = {dv_rem_reg[t-1][k], dv_nq_reg[t-1][k][QB-1]};
                diff[k]  = trial[k] - {1'b0, dv_d_reg[t-1]};
                ge[k]    = trial[k] >= {1'b0, dv_d_reg[t-1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[6+t])
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dv_rem_reg[t][k]  <= ge[k] ? diff[k][DVW-1:0] : trial[k][DVW-1:0];
                    dv_nq_reg[t][k]   <= {dv_nq_reg[t-1][k][QB-2:0], ge[k]};
                    dv_side_reg[t][k] <= dv_side_reg[t-1][k];
                end
                dv_d_reg[t]  <= dv_d_reg[t-1];
                dv_dg_reg[t] <= dv_dg_reg[t-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: apply sign, add p0 in fixed point, saturate.
    logic signed [OUT_BITS-1:0] center_reg  [3];
    logic signed [OUT_BITS-1:0] center_next [3];
    logic                       dgf_reg;
    logic signed [SUMW-1:0]     qmag [3];
    logic signed [SUMW-1:0]     vsum [3];
    side_t                      sf   [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sf[k]   = dv_side_reg[QB][k];
            qmag[k] = sf[k].zero ? '0 : SUMW'(dv_nq_reg[QB][k]);
            vsum[k] = (SUMW'(sf[k].p0) <<< FRAC_BITS)
                    + (sf[k].neg ? ~qmag[k] : qmag[k])
                    + SUMW'(sf[k].neg);
            priority if (sf[k].ovf)
            begin
                center_next[k] = sf[k].neg ? OMIN[OUT_BITS-1:0] : OMAX[OUT_BITS-1:0];
            end
            else if (vsum[k] > OMAX)
            begin
                center_next[k] = OMAX[OUT_BITS-1:0];
            end
            else if (vsum[k] < OMIN)
            begin
                center_next[k] = OMIN[OUT_BITS-1:0];
            end
            else
            begin
                center_next[k] = vsum[k][OUT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST-1])
        begin
            center_reg <= center_next;
            dgf_reg    <= dv_dg_reg[QB];
        end
    end

    assign ctr.center_x   = center_reg[0];
    assign ctr.center_y   = center_reg[1];
    assign ctr.center_z   = center_reg[2];
    assign ctr.degenerate = dgf_reg;

    // ------------------------------------------------------------------
    // Checks.

    // An accepted beat always lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pts.valid && pts.ready |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // With no result waiting, the ready chain must be open end to end.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NST-1] |-> pts.ready)
        else $error("input stalled while the output stage is empty");

    // A taking receiver never stalls the input.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        ctr.ready |-> pts.ready)
        else $error("input stalled while the receiver is ready");

endmodule
